// ===== src/tpf_pkg.sv =====
// tpf_pkg: shared constants, codes and types for the tile pixel fetcher
// used by every module of the tile_pixel_fetcher_fifo block but tpf_ram, no dependencies
package tpf_pkg;

  // item kinds, carried on s_tuser
  localparam logic [1:0] OP_VRAM_WRITE = 2'd0;
  localparam logic [1:0] OP_DOT        = 2'd1;
  localparam logic [1:0] OP_POP        = 2'd2;
  localparam logic [1:0] OP_START      = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_SCROLL_X     = 3'd0;
  localparam logic [2:0] REG_SCROLL_Y     = 3'd1;
  localparam logic [2:0] REG_WINDOW_X     = 3'd2;
  localparam logic [2:0] REG_WINDOW_Y     = 3'd3;
  localparam logic [2:0] REG_BG_MAP_HIGH  = 3'd4;
  localparam logic [2:0] REG_WIN_MAP_HIGH = 3'd5;
  localparam logic [2:0] REG_BG_ENABLE    = 3'd6;
  localparam logic [2:0] REG_PALETTE      = 3'd7;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int VRAM_BYTES      = 8192;
  localparam int VRAM_AW         = 13;
  localparam int ROW_PIXELS      = 8;
  localparam int ROW_W           = 2 * ROW_PIXELS;
  localparam int LEVEL_W         = 5;
  localparam int IN_TDATA_W      = 32;
  localparam int OUT_TDATA_W     = 8;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 8;

  typedef struct packed {
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] window_x;
    logic [7:0] window_y;
    logic       bg_map_high;
    logic       win_map_high;
    logic       bg_enable;
    logic [7:0] palette;
  } cfg_t;

  // one row of eight shades, leftmost pixel in the lowest bits
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
  } push_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               empty;
    logic [1:0]         shade;
  } res_t;

endpackage

// ===== src/tile_pixel_fetcher_fifo.sv =====
// tile_pixel_fetcher_fifo: top level, stream ports, configuration registers
// depends on tpf_pkg, tpf_fetcher, tpf_queue and tpf_out_buf
//
// Background and window pixel fetcher for a tile display. Every item on the slave
// stream is one of four kinds, given on s_tuser: a video ram write, a dot tick, a
// pixel pop or a line start. The block takes one item per clock cycle while
// s_tready is high. Only pops give a result; it shows on the master stream
// after the registered read of the shade row ram and a register in the result
// buffer. The three-slot result buffer sets the only stall: s_tready drops when
// the buffer and the pop in flight would leave no room if the sink stalls, so with
// m_tready held high pops flow at one per cycle. The fetcher acts on every other
// dot and reads video ram in its tile, low plane and high plane steps, one
// read each, landing before its next active dot. The shade fifo lives in
// a ram of QUEUE_DEPTH/8 rows of eight shades; QUEUE_DEPTH must be a multiple of
// 8. There is no clearing pass: video ram that was never written reads as garbage.
module tile_pixel_fetcher_fifo #(
  parameter int QUEUE_DEPTH = tpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: vram_addr[12:0], vram_data[20:13], line_number[28:21], zero fill
  input  logic [tpf_pkg::IN_TDATA_W-1:0]      s_tdata,
  // s_tuser: opcode[1:0]
  input  logic [1:0]                          s_tuser,
  // master stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: shade[1:0], fifo_level[6:2], zero fill
  output logic [tpf_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // m_tuser: fifo_empty
  output logic                                m_tuser,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [tpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tpf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  tpf_pkg::cfg_t  cfg;
  tpf_pkg::push_t push;
  tpf_pkg::res_t  res;
  tpf_pkg::res_t  out_res;

  logic       acc;
  logic [1:0] opcode;
  logic       push_room;
  logic       res_valid;
  logic       space_ok;

  // transaction on the slave side
  assign acc      = s_tvalid && s_tready;
  assign opcode   = s_tuser;
  assign s_tready = space_ok;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scroll_x     <= 8'd0;
      cfg.scroll_y     <= 8'd0;
      cfg.window_x     <= 8'd0;
      cfg.window_y     <= 8'd0;
      cfg.bg_map_high  <= 1'b0;
      cfg.win_map_high <= 1'b0;
      cfg.bg_enable    <= 1'b1;
      cfg.palette      <= 8'd252;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpf_pkg::REG_SCROLL_X:     cfg.scroll_x     <= cfg_data;
        tpf_pkg::REG_SCROLL_Y:     cfg.scroll_y     <= cfg_data;
        tpf_pkg::REG_WINDOW_X:     cfg.window_x     <= cfg_data;
        tpf_pkg::REG_WINDOW_Y:     cfg.window_y     <= cfg_data;
        tpf_pkg::REG_BG_MAP_HIGH:  cfg.bg_map_high  <= cfg_data[0];
        tpf_pkg::REG_WIN_MAP_HIGH: cfg.win_map_high <= cfg_data[0];
        tpf_pkg::REG_BG_ENABLE:    cfg.bg_enable    <= cfg_data[0];
        tpf_pkg::REG_PALETTE:      cfg.palette      <= cfg_data;
        default: ;
      endcase
    end
  end

  // fetcher with the video ram, hands finished rows to the queue
  tpf_fetcher u_fetcher (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .opcode     (opcode),
    .vram_addr  (s_tdata[12:0]),
    .vram_data  (s_tdata[20:13]),
    .line_number(s_tdata[28:21]),
    .cfg        (cfg),
    .push_room  (push_room),
    .push       (push)
  );

  // shade fifo, pop results come back in the cycle after the pop
  tpf_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .opcode   (opcode),
    .push     (push),
    .push_room(push_room),
    .res_valid(res_valid),
    .res      (res)
  );

  // result buffer decouples the master side
  tpf_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .in_valid(res_valid),
    .in_res  (res),
    .space_ok(space_ok),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .out_res (out_res)
  );

  assign m_tdata = {1'b0, out_res.level, out_res.shade};
  assign m_tuser = out_res.empty;

  // a stall on the slave side always has a result waiting
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> m_tvalid)
    else $error("slave side stalled with no result pending");

  // every pop transaction gives a result in flight on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (acc && opcode == tpf_pkg::OP_POP) |=> res_valid)
    else $error("pop transaction lost its result");

  // items other than pops never make a result
  assert property (@(posedge clk) disable iff (rst)
    (!acc || opcode != tpf_pkg::OP_POP) |=> !res_valid)
    else $error("result appeared without a pop transaction");

  // an empty-queue result always reports level zero and shade three
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.empty) |-> (res.level == '0 && res.shade == 2'b11))
    else $error("empty pop result carries a bad level or shade");

endmodule

// ===== src/tpf_ram.sv =====
// tpf_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
module tpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tpf_fetcher.sv =====
// tpf_fetcher: video ram and the five-step tile fetcher that builds rows of shades
// depends on tpf_pkg and tpf_ram
module tpf_fetcher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          acc,
  input  logic [1:0]                    opcode,
  input  logic [tpf_pkg::VRAM_AW-1:0]   vram_addr,
  input  logic [7:0]                    vram_data,
  input  logic [7:0]                    line_number,
  input  tpf_pkg::cfg_t                 cfg,
  input  logic                          push_room,
  output tpf_pkg::push_t                push
);

  localparam logic [2:0] STEP_TILE  = 3'd0;
  localparam logic [2:0] STEP_LOW   = 3'd1;
  localparam logic [2:0] STEP_HIGH  = 3'd2;
  localparam logic [2:0] STEP_SLEEP = 3'd3;
  localparam logic [2:0] STEP_PUSH  = 3'd4;

  logic [2:0] step;
  logic       dot_phase;
  logic [7:0] fetch_x;
  logic [7:0] current_line;
  logic [7:0] tile_number;
  logic [7:0] plane_low;
  logic [7:0] plane_high;
  logic       cap_tile;
  logic       cap_low;
  logic       cap_high;

  logic                        dot;
  logic                        start;
  logic                        act;
  logic                        vram_we;
  logic                        vram_re;
  logic [tpf_pkg::VRAM_AW-1:0] vram_raddr;
  logic [7:0]                  vram_q;
  logic [7:0]                  map_x;
  logic [7:0]                  map_y;
  logic                        in_window;
  logic                        map_high;
  logic [tpf_pkg::ROW_W-1:0]   row;

  assign dot     = acc && (opcode == tpf_pkg::OP_DOT);
  assign start   = acc && (opcode == tpf_pkg::OP_START);
  assign act     = dot && !dot_phase;
  assign vram_we = acc && (opcode == tpf_pkg::OP_VRAM_WRITE);
  assign vram_re = act && (step == STEP_TILE || step == STEP_LOW || step == STEP_HIGH);

  assign map_x     = fetch_x + cfg.scroll_x;
  assign map_y     = current_line + cfg.scroll_y;
  assign in_window = (fetch_x > cfg.window_x) && (current_line > cfg.window_y);
  assign map_high  = in_window ? cfg.win_map_high : cfg.bg_map_high;

  always_comb begin
    if (step == STEP_TILE) begin
      // map base 0x1800 or 0x1c00, then 32 tiles per map row
      vram_raddr = {2'b11, map_high, map_y[7:3], map_x[7:3]};
    end else begin
      vram_raddr = {1'b0, tile_number, map_y[2:0], (step == STEP_HIGH)};
    end
  end

  tpf_ram #(
    .WIDTH(8),
    .DEPTH(tpf_pkg::VRAM_BYTES)
  ) u_vram (
    .clk  (clk),
    .we   (vram_we),
    .waddr(vram_addr),
    .wdata(vram_data),
    .re   (vram_re),
    .raddr(vram_raddr),
    .rdata(vram_q)
  );

  // palette lookup per pixel, bit 7 is the leftmost pixel and goes first
  always_comb begin
    logic [1:0] colour;
    row = '0;
    for (int i = 0; i < tpf_pkg::ROW_PIXELS; i++) begin
      colour = {plane_high[tpf_pkg::ROW_PIXELS-1-i], plane_low[tpf_pkg::ROW_PIXELS-1-i]};
      if (!cfg.bg_enable) begin
        colour = 2'd0;
      end
      row[2*i +: 2] = cfg.palette[2*colour +: 2];
    end
  end

  assign push.valid = act && (step == STEP_PUSH) && push_room;
  assign push.row   = row;

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= STEP_TILE;
      dot_phase    <= 1'b0;
      fetch_x      <= '0;
      current_line <= '0;
      tile_number  <= '0;
      plane_low    <= '0;
      plane_high   <= '0;
      cap_tile     <= 1'b0;
      cap_low      <= 1'b0;
      cap_high     <= 1'b0;
    end else if (start) begin
      step         <= STEP_TILE;
      dot_phase    <= 1'b0;
      fetch_x      <= '0;
      current_line <= line_number;
      tile_number  <= '0;
      plane_low    <= '0;
      plane_high   <= '0;
      cap_tile     <= 1'b0;
      cap_low      <= 1'b0;
      cap_high     <= 1'b0;
    end else begin
      // read data lands in the cycle after the request
      cap_tile <= 1'b0;
      cap_low  <= 1'b0;
      cap_high <= 1'b0;
      if (cap_tile) begin
        tile_number <= vram_q;
      end
      if (cap_low) begin
        plane_low <= vram_q;
      end
      if (cap_high) begin
        plane_high <= vram_q;
      end
      if (dot) begin
        dot_phase <= ~dot_phase;
      end
      if (act) begin
        unique case (step)
          STEP_TILE: begin
            cap_tile <= 1'b1;
            fetch_x  <= fetch_x + 8'd8;
            step     <= STEP_LOW;
          end
          STEP_LOW: begin
            cap_low <= 1'b1;
            step    <= STEP_HIGH;
          end
          STEP_HIGH: begin
            cap_high <= 1'b1;
            step     <= STEP_SLEEP;
          end
          STEP_SLEEP: begin
            step <= STEP_PUSH;
          end
          STEP_PUSH: begin
            if (push_room) begin
              step <= STEP_TILE;
            end
          end
          default: begin
            step <= STEP_TILE;
          end
        endcase
      end
    end
  end

endmodule

// ===== src/tpf_queue.sv =====
// tpf_queue: shade fifo kept as rows of eight shades in a ram, with pop read stage
// depends on tpf_pkg and tpf_ram
module tpf_queue #(
  parameter int QUEUE_DEPTH = tpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           acc,
  input  logic [1:0]     opcode,
  input  tpf_pkg::push_t push,
  output logic           push_room,
  output logic           res_valid,
  output tpf_pkg::res_t  res
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int ROWS   = QUEUE_DEPTH / tpf_pkg::ROW_PIXELS;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [PTR_W-1:0] read_ptr;
  logic [CNT_W-1:0] count;
  logic             s1_empty;
  logic [2:0]       s1_sel;
  logic [tpf_pkg::LEVEL_W-1:0] s1_level;

  logic                      pop;
  logic                      start;
  logic                      is_empty;
  logic                      row_re;
  logic [SUM_W-1:0]          wsum;
  logic [SUM_W-1:0]          widx;
  logic [ROW_AW-1:0]         wrow;
  logic [ROW_AW-1:0]         rrow;
  logic [tpf_pkg::ROW_W-1:0] row_q;
  logic [PTR_W-1:0]          ptr_inc;

  assign pop      = acc && (opcode == tpf_pkg::OP_POP);
  assign start    = acc && (opcode == tpf_pkg::OP_START);
  assign is_empty = (count == '0);
  assign row_re   = pop && !is_empty;

  // the write position only ever moves by whole rows, so it stays row aligned
  assign wsum = SUM_W'(read_ptr) + SUM_W'(count);
  assign widx = (wsum >= SUM_W'(QUEUE_DEPTH)) ? wsum - SUM_W'(QUEUE_DEPTH) : wsum;
  assign wrow = ROW_AW'(widx >> 3);
  assign rrow = ROW_AW'(read_ptr >> 3);

  assign push_room = (SUM_W'(count) + SUM_W'(tpf_pkg::ROW_PIXELS)) <= SUM_W'(QUEUE_DEPTH);

  assign ptr_inc = (read_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : read_ptr + 1'b1;

  tpf_ram #(
    .WIDTH(tpf_pkg::ROW_W),
    .DEPTH(ROWS)
  ) u_rows (
    .clk  (clk),
    .we   (push.valid),
    .waddr(wrow),
    .wdata(push.row),
    .re   (row_re),
    .raddr(rrow),
    .rdata(row_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr  <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= pop;
      if (start) begin
        read_ptr <= '0;
        count    <= '0;
      end else if (push.valid) begin
        count <= count + CNT_W'(tpf_pkg::ROW_PIXELS);
      end else if (row_re) begin
        read_ptr <= ptr_inc;
        count    <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_empty <= is_empty;
      s1_sel   <= read_ptr[2:0];
      s1_level <= is_empty ? '0 : tpf_pkg::LEVEL_W'(count - 1'b1);
    end
  end

  assign res.empty = s1_empty;
  assign res.level = s1_level;
  assign res.shade = s1_empty ? 2'b11 : row_q[2*s1_sel +: 2];

endmodule

// ===== src/tpf_out_buf.sv =====
// tpf_out_buf: three-slot result buffer in front of the master stream port
// depends on tpf_pkg
module tpf_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  tpf_pkg::res_t in_res,
  output logic          space_ok,
  output logic          m_tvalid,
  input  logic          m_tready,
  output tpf_pkg::res_t out_res
);

  localparam int SLOTS = 3;

  tpf_pkg::res_t ent [SLOTS];
  logic [1:0]    cnt;
  logic          take;
  logic [1:0]    wpos;

  assign m_tvalid = (cnt != 2'd0);
  assign take     = m_tvalid && m_tready;
  assign wpos     = cnt - 2'(take);
  assign out_res  = ent[0];

  // a result in flight plus the held ones must fit even if the sink stalls
  assign space_ok = ({1'b0, cnt} + 3'(in_valid)) <= 3'(SLOTS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(in_valid) - 2'(take);
    end
  end

  // each slot either takes the new result or shifts down on a take
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS - 1; i++) begin
      if (in_valid && wpos == 2'(i)) begin
        ent[i] <= in_res;
      end else if (take) begin
        ent[i] <= ent[i+1];
      end
    end
    if (in_valid && wpos == 2'(SLOTS - 1)) begin
      ent[SLOTS-1] <= in_res;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for tile_pixel_fetcher_fifo
// depends on tpf_pkg and the tile_pixel_fetcher_fifo rtl, nothing else
// a shadow fetcher predicts every pop, a checker compares each result in order
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_HALF_NS   = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 6;           // result latency plus a fetcher read, with margin
  localparam int TOTAL_ITEMS   = 1150;
  localparam int TIMEOUT_NS    = 15_000_000;  // far above the slowest legal run
  localparam int MAP_LOW_BASE  = 'h1800;
  localparam int MAP_HIGH_BASE = 'h1C00;

  // fetcher steps of the shadow model
  typedef enum logic [2:0] {
    FETCH_TILE, FETCH_LOW, FETCH_HIGH, FETCH_SLEEP, FETCH_PUSH
  } fetch_step_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_BURSTY
  } sink_mode_t;

  // random item mixes
  typedef enum logic [1:0] {
    MIX_BALANCED, MIX_DOT_HEAVY, MIX_POP_HEAVY
  } item_mix_t;

  // dut ports, every input known from time zero
  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [tpf_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [1:0]                      s_tuser   = tpf_pkg::OP_DOT;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [tpf_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tuser;
  logic                            cfg_we    = 1'b0;
  logic [tpf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tpf_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  // shadow copy of the block: registers, video ram, shade queue and fetcher
  tpf_pkg::cfg_t settings;
  logic [7:0]    vram_image [tpf_pkg::VRAM_BYTES];
  bit            vram_written [tpf_pkg::VRAM_BYTES];
  logic [1:0]    shade_q [tpf_pkg::QUEUE_DEPTH_DEF];
  int            shade_head;
  int            shade_count;
  fetch_step_t   fetch_step;
  logic          dot_odd;
  logic [7:0]    fetch_x;
  logic [7:0]    line_reg;
  logic [7:0]    tile_no;
  logic [7:0]    plane_lo;
  logic [7:0]    plane_hi;

  // predicted pop results, oldest first
  tpf_pkg::res_t pop_results [$];

  int         error_count = 0;
  int         items_sent  = 0;
  int         burst_left  = 0;
  bit         send_paced  = 1'b1;
  sink_mode_t sink_mode   = SINK_OPEN;
  int         sink_tick   = 0;
  int         stall_left  = 0;

  tile_pixel_fetcher_fifo i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // video ram byte the next dot reads, if it reads one
  function automatic bit dot_read_addr(output int addr);
    logic [7:0] sx;
    logic [7:0] sy;
    logic       in_window;
    sx   = fetch_x + settings.scroll_x;
    sy   = line_reg + settings.scroll_y;
    addr = 0;
    if (dot_odd) return 1'b0;
    case (fetch_step)
      FETCH_TILE: begin
        in_window = (fetch_x > settings.window_x) && (line_reg > settings.window_y);
        addr = ((in_window ? settings.win_map_high : settings.bg_map_high) ?
                MAP_HIGH_BASE : MAP_LOW_BASE) + int'(sx / 8) + int'(sy / 8) * 32;
        return 1'b1;
      end
      FETCH_LOW: begin
        addr = int'({tile_no, sy[2:0], 1'b0});
        return 1'b1;
      end
      FETCH_HIGH: begin
        addr = int'({tile_no, sy[2:0], 1'b1});
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // shadow fetcher: advance the model by one accepted item
  task automatic predict_item(logic [1:0] op, logic [12:0] addr, logic [7:0] data,
                              logic [7:0] line);
    tpf_pkg::res_t r;
    int            map_addr;
    int            colour;
    int            sel;
    case (op)
      tpf_pkg::OP_VRAM_WRITE: begin
        vram_image[addr]   = data;
        vram_written[addr] = 1'b1;
      end
      tpf_pkg::OP_DOT: begin
        // only even dots do work
        if (!dot_odd) begin
          void'(dot_read_addr(map_addr));
          case (fetch_step)
            FETCH_TILE: begin
              tile_no = vram_image[map_addr];
              fetch_x = fetch_x + 8'd8;
              fetch_step = FETCH_LOW;
            end
            FETCH_LOW: begin
              plane_lo = vram_image[map_addr];
              fetch_step = FETCH_HIGH;
            end
            FETCH_HIGH: begin
              plane_hi = vram_image[map_addr];
              fetch_step = FETCH_SLEEP;
            end
            FETCH_SLEEP: begin
              fetch_step = FETCH_PUSH;
            end
            default: begin
              // push only when a whole row fits, otherwise retry next even dot
              if (shade_count + tpf_pkg::ROW_PIXELS <= tpf_pkg::QUEUE_DEPTH_DEF) begin
                for (int b = 7; b >= 0; b--) begin
                  colour = {plane_hi[b], plane_lo[b]};
                  sel = settings.bg_enable ? colour : 0;
                  shade_q[(shade_head + shade_count) % tpf_pkg::QUEUE_DEPTH_DEF] =
                    settings.palette[sel*2 +: 2];
                  shade_count++;
                end
                fetch_step = FETCH_TILE;
              end
            end
          endcase
        end
        dot_odd = ~dot_odd;
      end
      tpf_pkg::OP_POP: begin
        if (shade_count == 0) begin
          r.shade = 2'd3;
          r.empty = 1'b1;
          r.level = '0;
        end else begin
          r.shade = shade_q[shade_head];
          shade_head = (shade_head + 1) % tpf_pkg::QUEUE_DEPTH_DEF;
          shade_count--;
          r.empty = 1'b0;
          r.level = shade_count[tpf_pkg::LEVEL_W-1:0];
        end
        pop_results.push_back(r);
      end
      default: begin
        // line start: fetcher and queue restart, registers and video ram kept
        shade_head = 0;
        shade_count = 0;
        fetch_step = FETCH_TILE;
        dot_odd = 1'b0;
        fetch_x = '0;
        line_reg = line;
        tile_no = '0;
        plane_lo = '0;
        plane_hi = '0;
      end
    endcase
  endtask

  // one slave transaction; the sender runs in bursts, with random gaps between when paced
  task automatic send_item(logic [1:0] op, logic [12:0] addr, logic [7:0] data,
                           logic [7:0] line);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, line, data, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(op, addr, data, line);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (send_paced) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // don't-care fields are random so every tdata bit but the zero fill toggles; a dot that would
  // read a video ram byte never written gets that byte written first
  task automatic send_op(logic [1:0] op);
    int a;
    if (op == tpf_pkg::OP_DOT && dot_read_addr(a) && !vram_written[a]) begin
      send_item(tpf_pkg::OP_VRAM_WRITE, 13'(a), pick_byte(), 8'($urandom_range(0, 153)));
    end
    send_item(op, 13'($urandom_range(0, tpf_pkg::VRAM_BYTES - 1)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 153)));
  endtask

  // stop sending, let every pop come back, then let the fetcher finish its read
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pop_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all eight registers while the block is idle
  task automatic apply_settings(tpf_pkg::cfg_t s);
    quiesce();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[tpf_pkg::CFG_INDEX_W-1:0];
      case (i[tpf_pkg::CFG_INDEX_W-1:0])
        tpf_pkg::REG_SCROLL_X:     cfg_data <= s.scroll_x;
        tpf_pkg::REG_SCROLL_Y:     cfg_data <= s.scroll_y;
        tpf_pkg::REG_WINDOW_X:     cfg_data <= s.window_x;
        tpf_pkg::REG_WINDOW_Y:     cfg_data <= s.window_y;
        tpf_pkg::REG_BG_MAP_HIGH:  cfg_data <= {7'b0, s.bg_map_high};
        tpf_pkg::REG_WIN_MAP_HIGH: cfg_data <= {7'b0, s.win_map_high};
        tpf_pkg::REG_BG_ENABLE:    cfg_data <= {7'b0, s.bg_enable};
        default:                   cfg_data <= s.palette;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings = s;
  endtask

  // a scanline: start, a run of dots, then a run of pops
  task automatic run_line(logic [7:0] line, int n_dots, int n_pops);
    send_item(tpf_pkg::OP_START, 13'($urandom_range(0, tpf_pkg::VRAM_BYTES - 1)),
              8'($urandom_range(0, 255)), line);
    repeat (n_dots) send_op(tpf_pkg::OP_DOT);
    repeat (n_pops) send_op(tpf_pkg::OP_POP);
  endtask

  function automatic logic [1:0] pick_op(item_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_DOT_HEAVY: begin
        if (r < 5) return tpf_pkg::OP_VRAM_WRITE;
        if (r < 80) return tpf_pkg::OP_DOT;
        if (r < 98) return tpf_pkg::OP_POP;
        return tpf_pkg::OP_START;
      end
      MIX_POP_HEAVY: begin
        if (r < 5) return tpf_pkg::OP_VRAM_WRITE;
        if (r < 45) return tpf_pkg::OP_DOT;
        if (r < 98) return tpf_pkg::OP_POP;
        return tpf_pkg::OP_START;
      end
      default: begin
        if (r < 8) return tpf_pkg::OP_VRAM_WRITE;
        if (r < 63) return tpf_pkg::OP_DOT;
        if (r < 96) return tpf_pkg::OP_POP;
        return tpf_pkg::OP_START;
      end
    endcase
  endfunction

  // reset settings: empty pop, field extremes, first row push, line restart
  task automatic test_fetch_basics();
    send_op(tpf_pkg::OP_POP);
    send_item(tpf_pkg::OP_VRAM_WRITE, 13'd0, 8'h00, 8'd0);
    send_item(tpf_pkg::OP_VRAM_WRITE, 13'd8191, 8'hFF, 8'd153);
    run_line(8'd153, 9, 2);
    // restart with shades still queued, then drain one past empty
    run_line(8'd0, 9, 9);
  endtask

  // extreme register settings; 40 dots fill the queue and force push retries
  task automatic test_register_extremes();
    tpf_pkg::cfg_t s;
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: s = '{scroll_x: 8'hFF, scroll_y: 8'hFF, window_x: 8'hFF, window_y: 8'hFF,
                 bg_map_high: 1'b1, win_map_high: 1'b0, bg_enable: 1'b1, palette: 8'h1B};
        1: s = '{scroll_x: 8'h00, scroll_y: 8'h00, window_x: 8'h00, window_y: 8'h00,
                 bg_map_high: 1'b0, win_map_high: 1'b1, bg_enable: 1'b1, palette: 8'hE4};
        2: s = '{scroll_x: 8'h80, scroll_y: 8'h7F, window_x: 8'h10, window_y: 8'h40,
                 bg_map_high: 1'b1, win_map_high: 1'b1, bg_enable: 1'b0, palette: 8'h02};
        default: s = '{scroll_x: 8'h07, scroll_y: 8'hFF, window_x: 8'h00, window_y: 8'hFF,
                       bg_map_high: 1'b0, win_map_high: 1'b0, bg_enable: 1'b1,
                       palette: 8'hFF};
      endcase
      apply_settings(s);
      run_line((k == 1) ? 8'd153 : 8'($urandom_range(0, 153)), 40, 17);
    end
  endtask

  // random phases: fresh settings, stall pattern and item mix per phase
  task automatic test_random_traffic();
    tpf_pkg::cfg_t s;
    item_mix_t     mix;
    int            n;
    while (items_sent < TOTAL_ITEMS) begin
      s.scroll_x     = pick_byte();
      s.scroll_y     = pick_byte();
      s.window_x     = pick_byte();
      s.window_y     = 8'($urandom_range(0, 160));
      s.bg_map_high  = 1'($urandom_range(0, 1));
      s.win_map_high = 1'($urandom_range(0, 1));
      s.bg_enable    = ($urandom_range(0, 3) != 0);
      s.palette      = pick_byte();
      apply_settings(s);
      sink_mode  <= sink_mode_t'($urandom_range(0, 3));
      send_paced = ($urandom_range(0, 3) != 0);
      mix = item_mix_t'($urandom_range(0, 2));
      n = $urandom_range(60, 140);
      // mostly whole scanlines; start lines inside the mix break them up
      send_item(tpf_pkg::OP_START, 13'($urandom_range(0, tpf_pkg::VRAM_BYTES - 1)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 153)));
      for (int j = 0; j < n && items_sent < TOTAL_ITEMS; j++) begin
        send_op(pick_op(mix));
      end
    end
  endtask

  // receiver stall patterns
  always @(posedge clk) begin
    sink_tick <= sink_tick + 1;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_OPEN:     m_tready <= 1'b1;
        SINK_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
        SINK_PERIODIC: m_tready <= ((sink_tick % 7) > 2);
        default: begin
          // mostly ready, with occasional long stalls
          if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
          end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(3, 12);
            m_tready   <= 1'b0;
          end else begin
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // result checker: each master transaction against the oldest predicted pop
  always @(posedge clk) begin
    tpf_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pop_results.size() == 0) begin
        report_error("result with no pop outstanding");
      end else begin
        want = pop_results.pop_front();
        if (m_tdata[1:0] !== want.shade)
          report_error($sformatf("shade got %0d expected %0d", m_tdata[1:0], want.shade));
        if (m_tuser !== want.empty)
          report_error($sformatf("fifo_empty got %0d expected %0d", m_tuser, want.empty));
        if (m_tdata[6:2] !== want.level)
          report_error($sformatf("fifo_level got %0d expected %0d", m_tdata[6:2], want.level));
      end
    end
  end

  initial begin
    // shadow state at its reset values
    settings = '{scroll_x: 8'h00, scroll_y: 8'h00, window_x: 8'h00, window_y: 8'h00,
                 bg_map_high: 1'b0, win_map_high: 1'b0, bg_enable: 1'b1, palette: 8'd252};
    predict_item(tpf_pkg::OP_START, '0, '0, 8'd0);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_paced = 1'b0;
    test_fetch_basics();
    send_paced = 1'b1;
    sink_mode <= SINK_BURSTY;
    test_register_extremes();
    test_random_traffic();

    // drain everything outstanding, then give the verdict
    quiesce();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
